/* rtl/mtse_pkg.sv */
// ----------------------------------------------------------------------------
// mtse_pkg: shared definitions for the multitouch slot event generator
// Holds field widths, event type and code values, command and register
// codes, default parameter values and the scale unit request/response types.
// ----------------------------------------------------------------------------
package mtse_pkg;

    // Fixed field widths.
    localparam int COORD_W = 16;
    localparam int TYPE_W  = 2;
    localparam int CODE_W  = 9;
    localparam int VALUE_W = 17;
    localparam int SLOT_W  = 4;
    localparam int ROT_W   = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Defaults for the top level parameters.
    localparam int SLOT_COUNT_DEF  = 10;
    localparam int PANEL_X_MAX_DEF = 14399;
    localparam int PANEL_Y_MAX_DEF = 31999;

    // Event types.
    localparam logic [TYPE_W-1:0] EV_SYN = 2'd0;
    localparam logic [TYPE_W-1:0] EV_KEY = 2'd1;
    localparam logic [TYPE_W-1:0] EV_ABS = 2'd3;

    // Event codes.
    localparam logic [CODE_W-1:0] CODE_REPORT = 9'h000;
    localparam logic [CODE_W-1:0] CODE_SLOT   = 9'h02f;
    localparam logic [CODE_W-1:0] CODE_TRACK  = 9'h039;
    localparam logic [CODE_W-1:0] CODE_POS_X  = 9'h035;
    localparam logic [CODE_W-1:0] CODE_POS_Y  = 9'h036;
    localparam logic [CODE_W-1:0] CODE_TOUCH  = 9'h14a;

    // Rotation code that selects the reflected X axis in landscape.
    localparam logic [ROT_W-1:0] ROT_90 = 3'd1;
    localparam logic [ROT_W-1:0] ROT_UNKNOWN = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROTATION     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BTN_ENABLE   = 2'd3;

    typedef enum logic [1:0] {
        MODE_DOWN  = 2'd0,
        MODE_MOVE  = 2'd1,
        MODE_UP    = 2'd2,
        MODE_RESET = 2'd3
    } t_mode;

    // Request to the shared scale unit: round(coord*lim/den) or its
    // reflection lim - coord*lim/den, clamped to 0..lim.
    typedef struct packed {
        logic               start;
        logic               reflect;
        logic [COORD_W-1:0] coord;
        logic [COORD_W-1:0] lim;
        logic [COORD_W-1:0] den;
    } t_scale_req;

    typedef struct packed {
        logic               done;
        logic [COORD_W-1:0] value;
    } t_scale_rsp;

endpackage

/* rtl/mtse_scale.sv */
// ----------------------------------------------------------------------------
// mtse_scale: shared coordinate scaling unit
// One multiply, then a restoring divide one quotient bit per cycle, giving
// floor((2*num + den) / (2*den)) clamped to 0..lim. A request that rounds to zero
// or clamps at the first check skips the divide.
// ----------------------------------------------------------------------------
module mtse_scale
    import mtse_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_scale_req i_req,
    output t_scale_rsp o_rsp
);

    localparam int QUO_W  = COORD_W;
    localparam int STEP_W = $clog2(QUO_W);
    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int T_W    = PROD_W + 2;
    localparam int DIV_W  = COORD_W + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIN
    } t_state;

    t_state                     r_state;
    logic signed [DIFF_W-1:0]   r_diff;
    logic [COORD_W-1:0]         r_lim;
    logic [COORD_W-1:0]         r_den;
    logic signed [PROD_W-1:0]   r_prod;
    logic [DIV_W-1:0]           r_rem;
    logic [QUO_W-1:0]           r_quo;
    logic [STEP_W-1:0]          r_cnt;
    logic                       r_done;
    logic [COORD_W-1:0]         r_value;

    logic [T_W-1:0]   w_t;
    logic [DIV_W-1:0] w_div;
    logic [DIV_W:0]   w_trial;
    logic             w_ge;
    logic             w_clamp;

    // The doubled numerator plus the denominator, sign extended.
    assign w_t     = {r_prod[PROD_W-1], r_prod, 1'b0} + {{(T_W - COORD_W){1'b0}}, r_den};
    assign w_div   = {r_den, 1'b0};
    assign w_trial = {r_rem, r_quo[QUO_W-1]};
    assign w_ge    = w_trial >= {1'b0, w_div};
    assign w_clamp = w_t[QUO_W+DIV_W-1:QUO_W] >= w_div;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= ((r_state == S_PREP) && (w_t[T_W-1] || w_clamp)) ||
                      (r_state == S_FIN);
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_lim <= i_req.lim;
                        r_den <= i_req.den;
                        if (i_req.reflect) begin
                            r_diff <= signed'({1'b0, i_req.den}) - signed'({1'b0, i_req.coord});
                        end else begin
                            r_diff <= signed'({1'b0, i_req.coord});
                        end
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(signed'({1'b0, r_lim})) * PROD_W'(r_diff);
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    if (w_t[T_W-1]) begin
                        // Below the half-way point of zero: rounds to zero.
                        r_value <= '0;
                        r_state <= S_IDLE;
                    end else if (w_clamp) begin
                        // Quotient would not fit the coordinate width, so it clamps.
                        r_value <= r_lim;
                        r_state <= S_IDLE;
                    end else begin
                        r_rem   <= w_t[QUO_W+DIV_W-1:QUO_W];
                        r_quo   <= w_t[QUO_W-1:0];
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= DIV_W'(w_trial - {1'b0, w_div});
                    end else begin
                        r_rem <= w_trial[DIV_W-1:0];
                    end
                    r_quo <= {r_quo[QUO_W-2:0], w_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_W'(QUO_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_value <= (r_quo > r_lim) ? r_lim : r_quo;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.value = r_value;

endmodule

/* rtl/multitouch_slot_event_generator.sv */
// ----------------------------------------------------------------------------
// multitouch_slot_event_generator: touch commands to multitouch input events
// Tracks busy contact slots and turns each command word into a run of event
// words ending in a report word; frame points are scaled to panel space.
// ----------------------------------------------------------------------------
// One command word is taken at a time; o_in_stall stays high until its last
// event word has been loaded into the output register. A down or move word
// runs the shared scale unit twice, once per axis; a zero frame dimension
// skips scaling, and the point is then mapped to zero. A session reset sweeps
// the slot map one slot per cycle, pausing at each busy slot while its release
// events are sent. A down, move or up word whose slot is at or above
// SLOT_COUNT is taken and produces nothing. The output register holds one
// event word, and the next word is loaded in the same cycle that the current
// one is taken. Configuration writes are meant to happen while no command is
// in progress.
// ----------------------------------------------------------------------------
module multitouch_slot_event_generator
    import mtse_pkg::*;
#(
    parameter int SLOT_COUNT  = SLOT_COUNT_DEF,
    parameter int PANEL_X_MAX = PANEL_X_MAX_DEF,
    parameter int PANEL_Y_MAX = PANEL_Y_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    // Command channel.
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_mode,
    input  logic [SLOT_W-1:0]            i_slot,
    input  logic [COORD_W-1:0]           i_contact_id,
    input  logic [COORD_W-1:0]           i_frame_x,
    input  logic [COORD_W-1:0]           i_frame_y,

    // Event channel.
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [TYPE_W-1:0]            o_event_type,
    output logic [CODE_W-1:0]            o_event_code,
    output logic signed [VALUE_W-1:0]    o_event_value,
    output logic                         o_last_event,

    // Configuration write port.
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    // Counter width that can hold SLOT_COUNT itself; slot index width.
    localparam int CNT_W   = $clog2(SLOT_COUNT + 1);
    localparam int SLOT_IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MAP_X,
        S_WAIT_X,
        S_WAIT_Y,
        S_KEY,
        S_SLOT,
        S_TRACK,
        S_POS_X,
        S_POS_Y,
        S_SWEEP,
        S_SYN
    } t_state;

    // Configuration registers.
    logic [COORD_W-1:0] r_frame_width;
    logic [COORD_W-1:0] r_frame_height;
    logic [ROT_W-1:0]   r_rotation;
    logic               r_btn_enable;

    // Slot map.
    logic [SLOT_COUNT-1:0] r_slot_busy;
    logic [CNT_W-1:0]      r_busy_count;

    // Sequencer and the command being worked on.
    t_state                r_state;
    t_mode                 r_mode;
    logic [SLOT_W-1:0]     r_slot;
    logic [COORD_W-1:0]    r_contact_id;
    logic [COORD_W-1:0]    r_frame_x;
    logic [COORD_W-1:0]    r_frame_y;
    logic                  r_key;
    logic [SLOT_COUNT-1:0] r_sweep_mask;
    logic [CNT_W-1:0]      r_idx;
    logic [COORD_W-1:0]    r_px;
    logic [COORD_W-1:0]    r_py;
    logic                  r_req_start;
    logic                  r_axis_y;

    // Output register.
    logic                  r_out_valid;
    logic [TYPE_W-1:0]     r_out_type;
    logic [CODE_W-1:0]     r_out_code;
    logic [VALUE_W-1:0]    r_out_value;
    logic                  r_out_last;

    logic                  w_accept;
    logic                  w_can_load;
    logic                  w_emit_state;
    logic                  w_slot_ok;
    logic [SLOT_IW-1:0]    w_slot_idx;
    logic                  w_slot_was_busy;
    logic                  w_landscape;
    logic                  w_rot90;
    logic                  w_zero_frame;
    t_mode                 w_mode;
    t_state                w_after_map;
    t_scale_req            w_req;
    t_scale_rsp            w_rsp;

    assign o_in_stall  = (r_state != S_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;

    // An event word may be loaded when the register is empty or being taken.
    assign w_can_load  = !r_out_valid || !i_out_stall;

    // States that load one event word each.
    assign w_emit_state = (r_state == S_KEY) || (r_state == S_SLOT) ||
                          (r_state == S_TRACK) || (r_state == S_POS_X) ||
                          (r_state == S_POS_Y) || (r_state == S_SYN);

    assign w_mode          = t_mode'(i_mode);
    assign w_slot_ok       = (5'(i_slot) < 5'(SLOT_COUNT));
    assign w_slot_idx      = i_slot[SLOT_IW-1:0];
    assign w_slot_was_busy = r_slot_busy[w_slot_idx];

    // Landscape frames swap the axes; there, rotation 90 reflects X and every other
    // rotation code reflects Y.
    assign w_landscape  = r_frame_width > r_frame_height;
    assign w_rot90      = (r_rotation == ROT_90);
    assign w_zero_frame = (r_frame_width == '0) || (r_frame_height == '0);

    // After mapping, a down word may lead with the touch key event.
    assign w_after_map = (r_mode == MODE_DOWN && r_key) ? S_KEY : S_SLOT;

    always_comb begin
        w_req.start = r_req_start;
        if (!r_axis_y) begin
            w_req.lim     = COORD_W'(PANEL_X_MAX);
            w_req.coord   = w_landscape ? r_frame_y : r_frame_x;
            w_req.den     = w_landscape ? r_frame_height : r_frame_width;
            w_req.reflect = w_landscape && w_rot90;
        end else begin
            w_req.lim     = COORD_W'(PANEL_Y_MAX);
            w_req.coord   = w_landscape ? r_frame_x : r_frame_y;
            w_req.den     = w_landscape ? r_frame_width : r_frame_height;
            w_req.reflect = w_landscape && !w_rot90;
        end
    end

    mtse_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= '0;
            r_frame_height <= '0;
            r_rotation     <= ROT_UNKNOWN;
            r_btn_enable   <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                CFG_ROTATION:     r_rotation     <= i_cfg_data[ROT_W-1:0];
                CFG_BTN_ENABLE:   r_btn_enable   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sequencer: the slot map is updated when a command is taken, and the
    // event words follow one per state, each waiting for room in the output
    // register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_slot_busy  <= '0;
            r_busy_count <= '0;
            r_req_start  <= 1'b0;
            r_axis_y     <= 1'b0;
        end else begin
            // The scale unit starts on the X axis after mapping begins, and on
            // the Y axis once the X answer is in.
            r_req_start <= ((r_state == S_MAP_X) && !w_zero_frame) ||
                           ((r_state == S_WAIT_X) && w_rsp.done);
            if (r_out_valid && !i_out_stall && !w_emit_state) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_mode       <= w_mode;
                        r_slot       <= i_slot;
                        r_contact_id <= i_contact_id;
                        r_frame_x    <= i_frame_x;
                        r_frame_y    <= i_frame_y;
                        if (w_mode == MODE_RESET) begin
                            // Snapshot the busy slots for the sweep, then free all.
                            r_sweep_mask <= r_slot_busy;
                            r_slot_busy  <= '0;
                            r_busy_count <= '0;
                            r_key        <= r_btn_enable && (r_busy_count != '0);
                            r_idx        <= '0;
                            r_state      <= S_SWEEP;
                        end else if (w_slot_ok) begin
                            unique case (w_mode)
                                MODE_DOWN: begin
                                    r_key <= r_btn_enable && (r_busy_count == '0);
                                    r_slot_busy[w_slot_idx] <= 1'b1;
                                    if (!w_slot_was_busy) begin
                                        r_busy_count <= r_busy_count + 1'b1;
                                    end
                                    r_state <= S_MAP_X;
                                end
                                MODE_MOVE: begin
                                    r_key   <= 1'b0;
                                    r_state <= S_MAP_X;
                                end
                                default: begin
                                    // Up: the key is released once no slot is busy.
                                    r_slot_busy[w_slot_idx] <= 1'b0;
                                    r_busy_count <= r_busy_count - CNT_W'(w_slot_was_busy);
                                    r_key <= r_btn_enable &&
                                        ((r_busy_count - CNT_W'(w_slot_was_busy)) == '0);
                                    r_state <= S_SLOT;
                                end
                            endcase
                        end
                    end
                end
                S_MAP_X: begin
                    if (w_zero_frame) begin
                        r_px    <= '0;
                        r_py    <= '0;
                        r_state <= w_after_map;
                    end else begin
                        r_axis_y <= 1'b0;
                        r_state  <= S_WAIT_X;
                    end
                end
                S_WAIT_X: begin
                    if (w_rsp.done) begin
                        r_px     <= w_rsp.value;
                        r_axis_y <= 1'b1;
                        r_state  <= S_WAIT_Y;
                    end
                end
                S_WAIT_Y: begin
                    if (w_rsp.done) begin
                        r_py    <= w_rsp.value;
                        r_state <= w_after_map;
                    end
                end
                S_KEY: begin
                    if (w_can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= EV_KEY;
                        r_out_code  <= CODE_TOUCH;
                        r_out_value <= VALUE_W'(r_mode == MODE_DOWN);
                        r_out_last  <= 1'b0;
                        r_state     <= (r_mode == MODE_DOWN) ? S_SLOT : S_SYN;
                    end
                end
                S_SLOT: begin
                    if (w_can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= EV_ABS;
                        r_out_code  <= CODE_SLOT;
                        r_out_value <= VALUE_W'(r_slot);
                        r_out_last  <= 1'b0;
                        r_state     <= (r_mode == MODE_MOVE) ? S_POS_X : S_TRACK;
                    end
                end
                S_TRACK: begin
                    if (w_can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= EV_ABS;
                        r_out_code  <= CODE_TRACK;
                        r_out_last  <= 1'b0;
                        if (r_mode == MODE_DOWN) begin
                            r_out_value <= {1'b0, r_contact_id};
                            r_state     <= S_POS_X;
                        end else if (r_mode == MODE_UP) begin
                            r_out_value <= '1;
                            r_state     <= r_key ? S_KEY : S_SYN;
                        end else begin
                            r_out_value <= '1;
                            r_idx       <= r_idx + 1'b1;
                            r_state     <= S_SWEEP;
                        end
                    end
                end
                S_POS_X: begin
                    if (w_can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= EV_ABS;
                        r_out_code  <= CODE_POS_X;
                        r_out_value <= {1'b0, r_px};
                        r_out_last  <= 1'b0;
                        r_state     <= S_POS_Y;
                    end
                end
                S_POS_Y: begin
                    if (w_can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= EV_ABS;
                        r_out_code  <= CODE_POS_Y;
                        r_out_value <= {1'b0, r_py};
                        r_out_last  <= 1'b0;
                        r_state     <= S_SYN;
                    end
                end
                S_SWEEP: begin
                    // Release each snapshotted slot in ascending order.
                    if (r_idx == CNT_W'(SLOT_COUNT)) begin
                        r_state <= r_key ? S_KEY : S_SYN;
                    end else if (r_sweep_mask[r_idx[SLOT_IW-1:0]]) begin
                        r_slot  <= SLOT_W'(r_idx);
                        r_state <= S_SLOT;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_SYN: begin
                    if (w_can_load) begin
                        r_out_valid <= 1'b1;
                        r_out_type  <= EV_SYN;
                        r_out_code  <= CODE_REPORT;
                        r_out_value <= '0;
                        r_out_last  <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_type  = r_out_type;
    assign o_event_code  = r_out_code;
    assign o_event_value = signed'(r_out_value);
    assign o_last_event  = r_out_last;

    // The busy count always matches the slot map.
    a_count_matches_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy_count == CNT_W'($countones(r_slot_busy)))
        else $error("busy count does not match the slot map");

    // A session reset or an in-range command always starts a run.
    a_accept_starts_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && (w_mode == MODE_RESET || w_slot_ok) |=> o_in_stall)
        else $error("accepted command did not start an event run");

    // The scale unit answers only while the sequencer waits for it.
    a_scale_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == S_WAIT_X || r_state == S_WAIT_Y))
        else $error("scale unit finished outside a mapping wait");

    // The report word is the only one that closes a run.
    a_last_is_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_last |-> r_out_type == EV_SYN)
        else $error("last event word is not a report");

endmodule
